>>> hw/rtl/pcp_pkg.sv
// shared widths, command and status types for the polyline closest point block
package pcp_pkg;

   localparam int COORD_BITS = 24;
   localparam int INDEX_BITS = 16;

   localparam int DIFF_W   = COORD_BITS + 1;
   localparam int MUL_W    = COORD_BITS + 2;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int DOT_W    = 2 * COORD_BITS + 3;
   localparam int LEN_W    = 2 * COORD_BITS + 2;
   localparam int BEST_W   = 2 * COORD_BITS + 2;
   localparam int DIST_W   = 2 * COORD_BITS + 1;
   localparam int ROOT_W   = COORD_BITS + 1;
   localparam int NUM_W    = 3 * COORD_BITS + 2;
   localparam int NT_W     = NUM_W + 1;
   localparam int REM_W    = 2 * COORD_BITS + 2;
   localparam int Q_W      = COORD_BITS + 1;
   localparam int ITER_W   = $clog2(COORD_BITS + 1);
   localparam int COUNT_W  = INDEX_BITS + 1;

   localparam int REQ_FIELDS_W = 4 * COORD_BITS;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 2 * COORD_BITS + DIST_W + ROOT_W + INDEX_BITS;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIFF,
      OP_DOT_X,
      OP_DOT_Y,
      OP_LEN_X,
      OP_LEN_Y,
      OP_LEN_SUM,
      OP_AT_START,
      OP_PAST_END,
      OP_PROJ_LO,
      OP_PROJ_HI,
      OP_PROJ_ACC,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_PROJ_END,
      OP_AT_VERTEX,
      OP_DQ_X,
      OP_DQ_Y,
      OP_DQ_CMP,
      OP_SQ_INIT,
      OP_SQ_STEP,
      OP_EMIT,
      OP_ADVANCE
   } op_type;

   typedef struct packed {
      op_type op;
      logic   axis;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic last;
      logic zero_len;
      logic dot_le0;
      logic dot_ge_len;
      logic past_end;
      logic iter_done;
      logic out_free;
   } status_type;

endpackage

>>> hw/rtl/pcp_control.sv
// sequencer that steps the datapath through one vertex
module pcp_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  pcp_pkg::status_type status,
   output pcp_pkg::cmd_type    cmd
);
   import pcp_pkg::*;

   typedef enum logic [22:0] {
      S_IDLE     = 23'h000001,
      S_ROUTE    = 23'h000002,
      S_DIFF     = 23'h000004,
      S_DOT_X    = 23'h000008,
      S_DOT_Y    = 23'h000010,
      S_LEN_X    = 23'h000020,
      S_LEN_Y    = 23'h000040,
      S_LEN_SUM  = 23'h000080,
      S_DECIDE   = 23'h000100,
      S_PROJ_LO  = 23'h000200,
      S_PROJ_HI  = 23'h000400,
      S_PROJ_ACC = 23'h000800,
      S_DIV_INIT = 23'h001000,
      S_DIV      = 23'h002000,
      S_PROJ_END = 23'h004000,
      S_DQ_X     = 23'h008000,
      S_DQ_Y     = 23'h010000,
      S_DQ_CMP   = 23'h020000,
      S_AFTER    = 23'h040000,
      S_SQ_INIT  = 23'h080000,
      S_SQ       = 23'h100000,
      S_EMIT     = 23'h200000,
      S_ADVANCE  = 23'h400000
   } state_type;

   state_type state_ff, state_in;
   logic      axis_ff, axis_in;
   logic      end_ff, end_in;
   op_type    op;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         axis_ff  <= 1'b0;
         end_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         end_ff   <= end_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      axis_in    = axis_ff;
      end_in     = end_ff;
      op         = OP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op       = OP_LOAD;
               state_in = S_ROUTE;
            end
         end
         S_ROUTE: begin
            axis_in = 1'b0;
            end_in  = status.count_zero;
            if (status.count_zero) begin
               if (status.last) begin
                  op       = OP_AT_VERTEX;
                  state_in = S_DQ_X;
               end else begin
                  state_in = S_ADVANCE;
               end
            end else begin
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            op       = OP_DIFF;
            state_in = S_DOT_X;
         end
         S_DOT_X: begin
            if (status.zero_len && !status.last) begin
               state_in = S_ADVANCE;
            end else begin
               op       = OP_DOT_X;
               state_in = S_DOT_Y;
            end
         end
         S_DOT_Y: begin
            op       = OP_DOT_Y;
            state_in = S_LEN_X;
         end
         S_LEN_X: begin
            op       = OP_LEN_X;
            state_in = S_LEN_Y;
         end
         S_LEN_Y: begin
            op       = OP_LEN_Y;
            state_in = S_LEN_SUM;
         end
         S_LEN_SUM: begin
            op       = OP_LEN_SUM;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            priority if (status.dot_le0) begin
               op       = OP_AT_START;
               state_in = S_DQ_X;
            end else if (status.dot_ge_len) begin
               op       = OP_PAST_END;
               state_in = S_AFTER;
            end else begin
               state_in = S_PROJ_LO;
            end
         end
         S_PROJ_LO: begin
            op       = OP_PROJ_LO;
            state_in = S_PROJ_HI;
         end
         S_PROJ_HI: begin
            op       = OP_PROJ_HI;
            state_in = S_PROJ_ACC;
         end
         S_PROJ_ACC: begin
            op       = OP_PROJ_ACC;
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            op       = OP_DIV_INIT;
            state_in = S_DIV;
         end
         S_DIV: begin
            op = OP_DIV_STEP;
            if (status.iter_done) begin
               state_in = S_PROJ_END;
            end
         end
         S_PROJ_END: begin
            op = OP_PROJ_END;
            if (!axis_ff) begin
               axis_in  = 1'b1;
               state_in = S_PROJ_LO;
            end else begin
               state_in = S_DQ_X;
            end
         end
         S_DQ_X: begin
            op       = OP_DQ_X;
            state_in = S_DQ_Y;
         end
         S_DQ_Y: begin
            op       = OP_DQ_Y;
            state_in = S_DQ_CMP;
         end
         S_DQ_CMP: begin
            op       = OP_DQ_CMP;
            state_in = S_AFTER;
         end
         S_AFTER: begin
            priority if (status.last && status.past_end && !end_ff) begin
               op       = OP_AT_VERTEX;
               end_in   = 1'b1;
               state_in = S_DQ_X;
            end else if (status.last) begin
               state_in = S_SQ_INIT;
            end else begin
               state_in = S_ADVANCE;
            end
         end
         S_SQ_INIT: begin
            op       = OP_SQ_INIT;
            state_in = S_SQ;
         end
         S_SQ: begin
            op = OP_SQ_STEP;
            if (status.iter_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               op       = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         S_ADVANCE: begin
            op       = OP_ADVANCE;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign cmd.op   = op;
   assign cmd.axis = axis_ff;

endmodule

>>> hw/rtl/pcp_datapath.sv
// registers, shared multiplier, divider and square root of the closest point search
module pcp_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pcp_pkg::cmd_type                      cmd,
   output pcp_pkg::status_type                   status,
   input  logic [pcp_pkg::REQ_DATA_W-1:0]        req_tdata,
   input  logic                                  req_tuser,
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic signed [pcp_pkg::COORD_BITS-1:0] out_x,
   output logic signed [pcp_pkg::COORD_BITS-1:0] out_y,
   output logic [pcp_pkg::DIST_W-1:0]            out_dist,
   output logic [pcp_pkg::ROOT_W-1:0]            out_root,
   output logic [pcp_pkg::INDEX_BITS-1:0]        out_seg
);
   import pcp_pkg::*;

   localparam int CB = COORD_BITS;

   logic signed [CB-1:0]     vin_x_ff, vin_y_ff, query_x_ff, query_y_ff;
   logic signed [CB-1:0]     prior_x_ff, prior_y_ff, cand_x_ff, cand_y_ff;
   logic signed [CB-1:0]     best_x_ff, best_y_ff;
   logic                     last_ff, past_end_ff;
   logic [BEST_W-1:0]        best_ff, dacc_ff;
   logic [INDEX_BITS-1:0]    best_seg_ff;
   logic [COUNT_W-1:0]       count_ff;
   logic signed [DIFF_W-1:0] v1x_ff, v1y_ff, v2x_ff, v2y_ff;
   logic signed [DOT_W-1:0]  dot_ff;
   logic [LEN_W-1:0]         len_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [NUM_W-1:0]         num_ff;
   logic [REM_W-1:0]         rem_ff;
   logic [Q_W-1:0]           dsh_ff, quo_ff;
   logic [ITER_W-1:0]        iter_ff;
   logic [BEST_W-1:0]        sq_sh_ff;
   logic [ROOT_W-1:0]        sq_res_ff;
   logic [ROOT_W:0]          sq_rem_ff;
   logic                     rsp_valid_ff;

   logic signed [MUL_W-1:0]  mul_a, mul_b, off, proj_sum;
   logic signed [DIFF_W-1:0] v1a, dq_x, dq_y;
   logic [DIFF_W-1:0]        mag;
   logic                     neg;
   logic [NT_W-1:0]          nt;
   logic [REM_W:0]           rem2, div_d, rem_sub;
   logic                     div_bit;
   logic [BEST_W-1:0]        dsum;
   logic [COUNT_W-1:0]       count_dec;
   logic [INDEX_BITS-1:0]    seg;
   logic [ROOT_W+2:0]        sq_r, sq_trial, sq_sub;
   logic                     sq_bit;
   logic                     out_free;

   assign v1a  = cmd.axis ? v1y_ff : v1x_ff;
   assign neg  = v1a[DIFF_W-1];
   assign mag  = neg ? DIFF_W'(-v1a) : DIFF_W'(v1a);
   assign dq_x = DIFF_W'(cand_x_ff) - DIFF_W'(query_x_ff);
   assign dq_y = DIFF_W'(cand_y_ff) - DIFF_W'(query_y_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_DOT_X: begin
            mul_a = MUL_W'(v1x_ff);
            mul_b = MUL_W'(v2x_ff);
         end
         OP_DOT_Y: begin
            mul_a = MUL_W'(v1y_ff);
            mul_b = MUL_W'(v2y_ff);
         end
         OP_LEN_X: begin
            mul_a = MUL_W'(v1x_ff);
            mul_b = MUL_W'(v1x_ff);
         end
         OP_LEN_Y: begin
            mul_a = MUL_W'(v1y_ff);
            mul_b = MUL_W'(v1y_ff);
         end
         OP_PROJ_LO: begin
            mul_a = $signed({1'b0, mag});
            mul_b = $signed({1'b0, dot_ff[CB:0]});
         end
         OP_PROJ_HI: begin
            mul_a = $signed({1'b0, mag});
            mul_b = $signed({2'b00, dot_ff[2*CB:CB+1]});
         end
         OP_DQ_X: begin
            mul_a = MUL_W'(dq_x);
            mul_b = MUL_W'(dq_x);
         end
         OP_DQ_Y: begin
            mul_a = MUL_W'(dq_y);
            mul_b = MUL_W'(dq_y);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // division step for the rounded projection offset
   assign nt      = {num_ff, 1'b0} + NT_W'(len_ff);
   assign rem2    = {rem_ff, dsh_ff[Q_W-1]};
   assign div_d   = {len_ff, 1'b0};
   assign div_bit = rem2 >= div_d;
   assign rem_sub = rem2 - div_d;
   assign off     = neg ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign proj_sum = MUL_W'(cmd.axis ? prior_y_ff : prior_x_ff) + off;

   assign dsum      = dacc_ff + prod_ff[BEST_W-1:0];
   assign count_dec = count_ff - COUNT_W'(1);
   assign seg       = (count_ff == '0) ? '0 : count_dec[INDEX_BITS-1:0];

   // square root digit step
   assign sq_r     = {sq_rem_ff, sq_sh_ff[BEST_W-1:BEST_W-2]};
   assign sq_trial = {1'b0, sq_res_ff, 2'b01};
   assign sq_bit   = sq_r >= sq_trial;
   assign sq_sub   = sq_r - sq_trial;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      unique case (cmd.op)
         OP_LOAD: begin
            vin_x_ff <= req_tdata[CB-1:0];
            vin_y_ff <= req_tdata[2*CB-1:CB];
            last_ff  <= req_tlast;
         end
         OP_DIFF: begin
            v1x_ff <= DIFF_W'(vin_x_ff) - DIFF_W'(prior_x_ff);
            v1y_ff <= DIFF_W'(vin_y_ff) - DIFF_W'(prior_y_ff);
            v2x_ff <= DIFF_W'(query_x_ff) - DIFF_W'(prior_x_ff);
            v2y_ff <= DIFF_W'(query_y_ff) - DIFF_W'(prior_y_ff);
         end
         OP_DOT_Y:   dot_ff <= $signed(prod_ff[DOT_W-1:0]);
         OP_LEN_X:   dot_ff <= dot_ff + $signed(prod_ff[DOT_W-1:0]);
         OP_LEN_Y:   len_ff <= prod_ff[LEN_W-1:0];
         OP_LEN_SUM: len_ff <= len_ff + prod_ff[LEN_W-1:0];
         OP_AT_START: begin
            cand_x_ff <= prior_x_ff;
            cand_y_ff <= prior_y_ff;
         end
         OP_PROJ_HI:  num_ff <= NUM_W'(prod_ff[2*CB+1:0]);
         OP_PROJ_ACC: num_ff <= num_ff + {prod_ff[2*CB:0], {(CB+1){1'b0}}};
         OP_DIV_INIT: begin
            rem_ff  <= nt[NT_W-1:CB+1];
            dsh_ff  <= nt[CB:0];
            quo_ff  <= '0;
            iter_ff <= ITER_W'(Q_W - 1);
         end
         OP_DIV_STEP: begin
            rem_ff  <= div_bit ? rem_sub[REM_W-1:0] : rem2[REM_W-1:0];
            dsh_ff  <= {dsh_ff[Q_W-2:0], 1'b0};
            quo_ff  <= {quo_ff[Q_W-2:0], div_bit};
            iter_ff <= iter_ff - ITER_W'(1);
         end
         OP_PROJ_END: begin
            if (cmd.axis) begin
               cand_y_ff <= proj_sum[CB-1:0];
            end else begin
               cand_x_ff <= proj_sum[CB-1:0];
            end
         end
         OP_AT_VERTEX: begin
            cand_x_ff <= vin_x_ff;
            cand_y_ff <= vin_y_ff;
         end
         OP_DQ_Y: dacc_ff <= prod_ff[BEST_W-1:0];
         OP_SQ_INIT: begin
            sq_sh_ff  <= best_ff;
            sq_res_ff <= '0;
            sq_rem_ff <= '0;
            iter_ff   <= ITER_W'(ROOT_W - 1);
         end
         OP_SQ_STEP: begin
            sq_sh_ff  <= {sq_sh_ff[BEST_W-3:0], 2'b00};
            sq_rem_ff <= sq_bit ? sq_sub[ROOT_W:0] : sq_r[ROOT_W:0];
            sq_res_ff <= {sq_res_ff[ROOT_W-2:0], sq_bit};
            iter_ff   <= iter_ff - ITER_W'(1);
         end
         OP_EMIT: begin
            out_x    <= best_x_ff;
            out_y    <= best_y_ff;
            out_dist <= best_ff[DIST_W-1:0];
            out_root <= sq_res_ff;
            out_seg  <= best_seg_ff;
         end
         default: begin
         end
      endcase
   end

   // tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         query_x_ff   <= '0;
         query_y_ff   <= '0;
         prior_x_ff   <= '0;
         prior_y_ff   <= '0;
         best_ff      <= '1;
         best_x_ff    <= '0;
         best_y_ff    <= '0;
         best_seg_ff  <= '0;
         past_end_ff  <= 1'b1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (cmd.op)
            OP_LOAD: begin
               if (req_tuser) begin
                  query_x_ff  <= req_tdata[3*CB-1:2*CB];
                  query_y_ff  <= req_tdata[4*CB-1:3*CB];
                  prior_x_ff  <= '0;
                  prior_y_ff  <= '0;
                  best_ff     <= '1;
                  best_x_ff   <= '0;
                  best_y_ff   <= '0;
                  best_seg_ff <= '0;
                  past_end_ff <= 1'b1;
                  count_ff    <= '0;
               end
            end
            OP_AT_START: past_end_ff <= 1'b0;
            OP_PROJ_LO:  past_end_ff <= 1'b0;
            OP_PAST_END: past_end_ff <= 1'b1;
            OP_DQ_CMP: begin
               if (dsum < best_ff) begin
                  best_ff     <= dsum;
                  best_x_ff   <= cand_x_ff;
                  best_y_ff   <= cand_y_ff;
                  best_seg_ff <= seg;
               end
            end
            OP_EMIT: begin
               rsp_valid_ff <= 1'b1;
               prior_x_ff   <= '0;
               prior_y_ff   <= '0;
               best_ff      <= '1;
               best_x_ff    <= '0;
               best_y_ff    <= '0;
               best_seg_ff  <= '0;
               past_end_ff  <= 1'b1;
               count_ff     <= '0;
            end
            OP_ADVANCE: begin
               prior_x_ff <= vin_x_ff;
               prior_y_ff <= vin_y_ff;
               if (count_ff != '1) begin
                  count_ff <= count_ff + COUNT_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid        = rsp_valid_ff;
   assign status.count_zero = count_ff == '0;
   assign status.last       = last_ff;
   assign status.zero_len   = (v1x_ff == '0) && (v1y_ff == '0);
   assign status.dot_le0    = dot_ff[DOT_W-1] || (dot_ff == '0);
   assign status.dot_ge_len = dot_ff >= $signed({1'b0, len_ff});
   assign status.past_end   = past_end_ff;
   assign status.iter_done  = iter_ff == '0;
   assign status.out_free   = out_free;

endmodule

>>> hw/rtl/polyline_closest_point.sv
// top level of the polyline closest point block
//
// channel  dir  handshake            payload
// req      in   req_tvalid/tready    tdata vertex and target, tuser first, tlast last
// rsp      out  rsp_tvalid/tready    tdata nearest point, distances, segment
//
// a vertex either opens a polyline, skips a zero-length segment, defers the end, tries the
// segment start, or, when the target projects inside the segment, runs two 25-step
// divisions on one divider; the last vertex adds the end check and the square root
// synchronous reset clears the search state and the held target
// a result waiting on rsp_tready stalls only the next last vertex
module polyline_closest_point (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // vertex_x, vertex_y, target_x, target_y
   input  logic [pcp_pkg::REQ_DATA_W-1:0] req_tdata,
   // first_vertex
   input  logic                           req_tuser,
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // nearest_x, nearest_y, dist_squared, dist_root, segment_index, zero fill
   output logic [pcp_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import pcp_pkg::*;

   cmd_type                 cmd;
   status_type              status;
   logic signed [COORD_BITS-1:0] out_x, out_y;
   logic [DIST_W-1:0]       out_dist;
   logic [ROOT_W-1:0]       out_root;
   logic [INDEX_BITS-1:0]   out_seg;

   pcp_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pcp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .out_x      (out_x),
      .out_y      (out_y),
      .out_dist   (out_dist),
      .out_root   (out_root),
      .out_seg    (out_seg)
   );

   assign rsp_tdata = RSP_DATA_W'({out_seg, out_root, out_dist, out_y, out_x});

endmodule

>>> hw/rtl/pcp_checker.sv
// port checks on the polyline closest point block, bound to the top level
module pcp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [pcp_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import pcp_pkg::*;

   localparam int DIST_LO = 2 * COORD_BITS;
   localparam int ROOT_LO = DIST_LO + DIST_W;
   localparam int SQ_W    = 2 * ROOT_W + 2;

   logic [SQ_W-1:0] root, root_inc, dsq;

   assign root     = SQ_W'(rsp_tdata[ROOT_LO+ROOT_W-1:ROOT_LO]);
   assign root_inc = root + SQ_W'(1);
   assign dsq      = SQ_W'(rsp_tdata[ROOT_LO-1:DIST_LO]);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_root_low: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (root * root) <= dsq)
      else $error("root too large for squared distance");

   a_root_high: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (root_inc * root_inc) > dsq)
      else $error("root too small for squared distance");

endmodule

bind polyline_closest_point pcp_checker u_pcp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
